// ----- hw/rtl/lss_pkg.sv -----
`timescale 1ns / 1ps

package lss_pkg;

  localparam int unsigned OpBits     = 2;
  localparam int unsigned StatusBits = 2;
  localparam int unsigned SlotBits   = 10;
  localparam int unsigned TicketInW  = 16;
  localparam int unsigned RndBits    = 31;
  localparam int unsigned RndCntW    = 5;

  typedef enum logic [OpBits-1:0] {
    OP_ADD    = 2'd0,
    OP_REMOVE = 2'd1,
    OP_DRAW   = 2'd2
  } op_e;

  typedef enum logic [StatusBits-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_ADD_SCAN,
    S_SUM_SCAN,
    S_MOD,
    S_SEL_SCAN,
    S_DONE
  } state_e;

endpackage

// ----- hw/rtl/lss_in_if.sv -----
`timescale 1ns / 1ps

interface lss_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [15:0] ticket_count;
  logic [9:0]  slot_index;
  logic [30:0] random_value;

  modport source (
    output valid, operation, ticket_count, slot_index, random_value,
    input  ready
  );

  modport sink (
    input  valid, operation, ticket_count, slot_index, random_value,
    output ready
  );
endinterface

// ----- hw/rtl/lss_out_if.sv -----
`timescale 1ns / 1ps

interface lss_out_if;
  logic       valid;
  logic       ready;
  logic [9:0] result_slot;
  logic [1:0] status;

  modport source (
    output valid, result_slot, status,
    input  ready
  );

  modport sink (
    input  valid, result_slot, status,
    output ready
  );
endinterface

// ----- hw/rtl/lss_ram.sv -----
`timescale 1ns / 1ps

module lss_ram #(
  parameter int unsigned Width = 17,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ----- hw/rtl/lottery_slot_scheduler_unit.sv -----
`timescale 1ns / 1ps
// channel  | port  | dir | payload
// ---------+-------+-----+-------------------------------------------------------
// request  | in_i  | in  | operation, ticket_count, slot_index, random_value
// result   | out_o | out | result_slot, status
//
// one request at a time on a single slot ram; one word out per request
// remove and unused codes go straight to the done state; add: linear scan for a free slot
// draw: sum scan, 31-step restoring modulo, select scan, all through one shared
// add/subtract unit
// after reset a clearing pass writes every slot free, with in_i not ready
// a result waiting on out_o holds the next one in the done state only

module lottery_slot_scheduler_unit
  import lss_pkg::*;
#(
  parameter int unsigned SLOT_COUNT  = 1024,
  parameter int unsigned TICKET_BITS = 16
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  lss_in_if.sink    in_i,
  lss_out_if.source out_o
);

  localparam int unsigned AW   = $clog2(SLOT_COUNT);
  localparam int unsigned CW   = AW + 1;
  localparam int unsigned TB   = TICKET_BITS;
  localparam int unsigned TW   = TB + AW;
  localparam int unsigned AluW = TW + 2;
  localparam int unsigned IW   = (AW > SlotBits) ? AW : SlotBits;
  localparam int unsigned RamW = TB + 1;

  state_e state_q, state_d;

  logic [CW-1:0]       cnt_q, cnt_d;
  logic                rd_vld_q, rd_vld_d;
  logic [AW-1:0]       rd_addr_q, rd_addr_d;
  logic [TB-1:0]       tkt_q, tkt_d;
  logic [RndBits-1:0]  rnd_q, rnd_d;
  logic [RndCntW-1:0]  bit_q, bit_d;
  logic [TW-1:0]       total_q, total_d;
  logic [TW-1:0]       rem_q, rem_d;
  logic [SlotBits-1:0] res_slot_q, res_slot_d;
  status_e             res_status_q, res_status_d;
  logic                out_vld_q, out_vld_d;
  logic [SlotBits-1:0] out_slot_q, out_slot_d;
  status_e             out_status_q, out_status_d;

  logic            ram_we;
  logic [AW-1:0]   ram_waddr;
  logic [RamW-1:0] ram_wdata;
  logic [RamW-1:0] ram_rdata;
  logic            rd_valid;
  logic [TB-1:0]   rd_tkt;

  logic            accept;
  logic            scanning;
  logic            issuing;
  logic            last_rd;
  logic            out_free;
  logic            idx_ok;
  logic [IW-1:0]   idx_ext;

  logic [AluW-1:0] alu_a, alu_b, alu_res;
  logic            alu_sub;
  logic            alu_neg;

  assign accept   = in_i.valid && in_i.ready;
  assign out_free = !out_vld_q || out_o.ready;
  assign rd_valid = ram_rdata[TB];
  assign rd_tkt   = ram_rdata[TB-1:0];
  assign scanning = (state_q == S_ADD_SCAN) || (state_q == S_SUM_SCAN) ||
                    (state_q == S_SEL_SCAN);
  assign issuing  = scanning && (cnt_q < CW'(SLOT_COUNT));
  assign last_rd  = rd_vld_q && (rd_addr_q == AW'(SLOT_COUNT - 1));
  assign idx_ok   = {22'd0, in_i.slot_index} < 32'(SLOT_COUNT);
  assign idx_ext  = IW'(in_i.slot_index);

  lss_ram #(
    .Width (RamW),
    .Depth (SLOT_COUNT)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (cnt_q[AW-1:0]),
    .rdata_o (ram_rdata)
  );

  // shared add/subtract unit: sum pass, modulo steps, countdown in select pass
  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b0;
    unique case (state_q)
      S_SUM_SCAN: begin
        alu_a = AluW'(total_q);
        alu_b = rd_valid ? AluW'(rd_tkt) : '0;
      end
      S_MOD: begin
        alu_a   = AluW'({rem_q, rnd_q[RndBits-1]});
        alu_b   = AluW'(total_q);
        alu_sub = 1'b1;
      end
      S_SEL_SCAN: begin
        alu_a   = AluW'(rem_q);
        alu_b   = rd_valid ? AluW'(rd_tkt) : '0;
        alu_sub = 1'b1;
      end
      default: begin
        alu_sub = 1'b0;
      end
    endcase
  end

  assign alu_res = alu_sub ? (alu_a - alu_b) : (alu_a + alu_b);
  assign alu_neg = alu_res[AluW-1];

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLEAR: begin
        if (cnt_q == CW'(SLOT_COUNT - 1)) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (accept) begin
          case (in_i.operation)
            OP_ADD:  state_d = S_ADD_SCAN;
            OP_DRAW: state_d = S_SUM_SCAN;
            default: state_d = S_DONE;
          endcase
        end
      end
      S_ADD_SCAN: begin
        if ((rd_vld_q && !rd_valid) || last_rd) state_d = S_DONE;
      end
      S_SUM_SCAN: begin
        if (last_rd) state_d = S_MOD;
      end
      S_MOD: begin
        if (total_q == '0) state_d = S_DONE;
        else if (bit_q == RndCntW'(RndBits - 1)) state_d = S_SEL_SCAN;
      end
      S_SEL_SCAN: begin
        if ((rd_vld_q && rd_valid && alu_neg) || last_rd) state_d = S_DONE;
      end
      S_DONE: begin
        if (out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    cnt_d        = cnt_q;
    rd_vld_d     = 1'b0;
    rd_addr_d    = rd_addr_q;
    tkt_d        = tkt_q;
    rnd_d        = rnd_q;
    bit_d        = bit_q;
    total_d      = total_q;
    rem_d        = rem_q;
    res_slot_d   = res_slot_q;
    res_status_d = res_status_q;
    out_vld_d    = out_vld_q && !out_o.ready;
    out_slot_d   = out_slot_q;
    out_status_d = out_status_q;
    ram_we       = 1'b0;
    ram_waddr    = cnt_q[AW-1:0];
    ram_wdata    = '0;

    if (issuing) begin
      cnt_d     = cnt_q + CW'(1);
      rd_vld_d  = 1'b1;
      rd_addr_d = cnt_q[AW-1:0];
    end

    unique case (state_q)
      S_CLEAR: begin
        ram_we = 1'b1;
        cnt_d  = cnt_q + CW'(1);
      end
      S_IDLE: begin
        if (accept) begin
          cnt_d        = '0;
          tkt_d        = TB'(in_i.ticket_count);
          rnd_d        = in_i.random_value;
          total_d      = '0;
          res_slot_d   = '0;
          res_status_d = ST_OK;
          if (in_i.operation == OP_REMOVE && idx_ok) begin
            ram_we    = 1'b1;
            ram_waddr = idx_ext[AW-1:0];
          end
        end
      end
      S_ADD_SCAN: begin
        if (rd_vld_q && !rd_valid) begin
          ram_we     = 1'b1;
          ram_waddr  = rd_addr_q;
          ram_wdata  = {1'b1, tkt_q};
          res_slot_d = SlotBits'(rd_addr_q);
        end else if (last_rd) begin
          res_status_d = ST_FULL;
        end
      end
      S_SUM_SCAN: begin
        if (rd_vld_q) total_d = alu_res[TW-1:0];
        if (last_rd) begin
          cnt_d = '0;
          rem_d = '0;
          bit_d = '0;
        end
      end
      S_MOD: begin
        if (total_q == '0) begin
          res_status_d = ST_EMPTY;
        end else begin
          // restoring step: shift in one bit of the random value
          if (!alu_neg) rem_d = alu_res[TW-1:0];
          else          rem_d = {rem_q[TW-2:0], rnd_q[RndBits-1]};
          rnd_d = {rnd_q[RndBits-2:0], 1'b0};
          bit_d = bit_q + RndCntW'(1);
        end
      end
      S_SEL_SCAN: begin
        if (rd_vld_q && rd_valid && alu_neg) begin
          res_slot_d = SlotBits'(rd_addr_q);
        end else begin
          if (rd_vld_q && rd_valid) rem_d = alu_res[TW-1:0];
          if (last_rd) res_status_d = ST_EMPTY;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_vld_d    = 1'b1;
          out_slot_d   = res_slot_q;
          out_status_d = res_status_q;
        end
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLEAR;
      cnt_q     <= '0;
      rd_vld_q  <= 1'b0;
      bit_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      rd_vld_q  <= rd_vld_d;
      bit_q     <= bit_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_addr_q    <= rd_addr_d;
    tkt_q        <= tkt_d;
    rnd_q        <= rnd_d;
    total_q      <= total_d;
    rem_q        <= rem_d;
    res_slot_q   <= res_slot_d;
    res_status_q <= res_status_d;
    out_slot_q   <= out_slot_d;
    out_status_q <= out_status_d;
  end

  assign in_i.ready        = (state_q == S_IDLE);
  assign out_o.valid       = out_vld_q;
  assign out_o.result_slot = out_slot_q;
  assign out_o.status      = out_status_q;

endmodule
